@@ hw/rtl/vsps_pkg.sv @@
// ============================================================================
// vsps_pkg
// Shared types and constants for the visual servo pick-and-place sequencer.
// ============================================================================
`default_nettype none

package vsps_pkg;

    // Queue sizes
    localparam int IQ_DEPTH = 4;
    localparam int IQ_AW    = $clog2(IQ_DEPTH);
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_Y_STEP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_X_STEP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STABLE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LOST_MAX  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP  = 3'd5;

    // Register reset values
    localparam logic signed [10:0] RST_Y_STEP   = -11'sd15;
    localparam logic signed [10:0] RST_X_STEP   = 11'sd30;
    localparam logic [7:0]         RST_DEADBAND = 8'd8;
    localparam logic [7:0]         RST_STABLE   = 8'd3;
    localparam logic [7:0]         RST_LOST_MAX = 8'd10;
    localparam logic [12:0]        RST_MAX_STEP = 13'd500;

    // Image centre
    localparam logic signed [9:0] MID_X = 10'sd160;
    localparam logic signed [8:0] MID_Y = 9'sd120;

    // Coordinates, 0.001 cm
    localparam logic signed [15:0] CAP_X   = 16'sd15000;
    localparam logic signed [15:0] CAP_Y   = 16'sd0;
    localparam logic signed [15:0] CAP_Z   = -16'sd3000;
    localparam logic signed [15:0] APPR_Z  = 16'sd4000;
    localparam logic signed [15:0] GRAB_Z  = -16'sd7000;
    localparam logic signed [15:0] PLACE_Z = -16'sd5000;
    localparam logic signed [15:0] RED_X   = 16'sd5000;
    localparam logic signed [15:0] RED_Y   = 16'sd12000;
    localparam logic signed [15:0] GRN_X   = 16'sd5000;
    localparam logic signed [15:0] GRN_Y   = -16'sd12000;
    localparam logic signed [15:0] BLU_X   = 16'sd20000;
    localparam logic signed [15:0] BLU_Y   = 16'sd0;
    localparam logic signed [17:0] X_MIN   = 18'sd10000;
    localparam logic signed [17:0] X_MAX   = 18'sd20000;
    localparam logic signed [17:0] Y_MIN   = -18'sd10000;
    localparam logic signed [17:0] Y_MAX   = 18'sd10000;

    // Color ids
    localparam logic [7:0] COLOR_RED   = 8'd1;
    localparam logic [7:0] COLOR_GREEN = 8'd2;
    localparam logic [7:0] COLOR_BLUE  = 8'd3;

    // Motion times, ms
    localparam logic [9:0] T_TRACK = 10'd80;
    localparam logic [9:0] T_HOME  = 10'd500;
    localparam logic [9:0] T_MOVE  = 10'd1000;
    localparam logic [9:0] T_CLAW  = 10'd200;
    localparam logic [9:0] T_NONE  = 10'd0;

    localparam logic [7:0] CLAW_OPEN = 8'd90;
    localparam logic [7:0] CLAW_NONE = 8'd0;

    // Command codes
    typedef enum logic [1:0] {
        CMD_NONE = 2'd0,
        CMD_ARM  = 2'd1,
        CMD_CLAW = 2'd2
    } vsps_cmd_t;

    // Sequence phases
    typedef enum logic [3:0] {
        PH_DETECT   = 4'd0,
        PH_TRACK_Y  = 4'd1,
        PH_TRACK_X  = 4'd2,
        PH_APPROACH = 4'd3,
        PH_GRAB     = 4'd4,
        PH_CLOSE    = 4'd5,
        PH_LIFT     = 4'd6,
        PH_PLACE    = 4'd7,
        PH_RETURN   = 4'd8
    } vsps_phase_t;

    // Back-end control states
    typedef enum logic [1:0] {
        CS_IDLE  = 2'd0,
        CS_MUL   = 2'd1,
        CS_EXEC  = 2'd2,
        CS_OPEN  = 2'd3
    } vsps_cstate_t;

    // Classified report, front to back
    typedef struct packed {
        logic              found;
        logic              sortable;
        logic [7:0]        color;
        logic signed [9:0] err_x;
        logic signed [8:0] err_y;
    } vsps_item_t;

    // One result
    typedef struct packed {
        vsps_cmd_t          command;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic [7:0]         claw_angle;
        logic [9:0]         move_time_ms;
        logic [3:0]         phase;
        logic               last;
    } vsps_result_t;

    // Result queue status seen by the back end
    typedef struct packed {
        logic room2;
    } vsps_oq_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/visual_servo_pick_place_sequencer_unit.sv @@
// ============================================================================
// visual_servo_pick_place_sequencer_unit
// Camera-driven pick-and-place sequencer: report queue, sequencer, result queue.
// ============================================================================
//
//  Channel   Ports                                   Transfer when
//  -------   -------------------------------------   ----------------------
//  report    push, full, found, blob_color,          push && !full
//            blob_x, blob_y
//  result    empty, pop, command, pos_x, pos_y,      pop && !empty
//            pos_z, claw_angle, move_time_ms,
//            phase, last
//  config    cfg_we, cfg_index, cfg_wdata            cfg_we
//
//  The sequencer handles one report at a time, in control states IDLE, MUL
//  and EXEC (the place step adds OPEN and yields two results): pop from the
//  report queue, registered multiply, then clamp, update and result write.
//  A report needs two free result-queue slots to start; the report queue
//  holds 4 items and keeps taking transfers while results wait.
//  rst_n clears queues, phase state and registers to their defaults at once.
// ============================================================================
`default_nettype none

module visual_servo_pick_place_sequencer_unit
    import vsps_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Reports
    input  wire logic                  push,
    output logic                       full,
    input  wire logic                  found,
    input  wire logic [7:0]            blob_color,
    input  wire logic [8:0]            blob_x,
    input  wire logic [7:0]            blob_y,
    // Results
    output logic                       empty,
    input  wire logic                  pop,
    output logic [1:0]                 command,
    output logic signed [15:0]         pos_x,
    output logic signed [15:0]         pos_y,
    output logic signed [15:0]         pos_z,
    output logic [7:0]                 claw_angle,
    output logic [9:0]                 move_time_ms,
    output logic [3:0]                 phase,
    output logic                       last,
    // Configuration
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    vsps_item_t    item;
    logic          item_valid;
    logic          item_take;
    vsps_oq_stat_t oq_stat;
    logic          res_push;
    vsps_result_t  res;
    vsps_result_t  head;

    // Report intake
    vsps_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .found      (found),
        .blob_color (blob_color),
        .blob_x     (blob_x),
        .blob_y     (blob_y),
        .item       (item),
        .item_valid (item_valid),
        .item_take  (item_take)
    );

    // Sequencer
    vsps_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .item       (item),
        .item_valid (item_valid),
        .item_take  (item_take),
        .oq_stat    (oq_stat),
        .res_push   (res_push),
        .res_out    (res)
    );

    // Result queue
    vsps_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res_in   (res),
        .stat     (oq_stat),
        .empty    (empty),
        .pop      (pop),
        .head     (head)
    );

    assign command      = head.command;
    assign pos_x        = head.pos_x;
    assign pos_y        = head.pos_y;
    assign pos_z        = head.pos_z;
    assign claw_angle   = head.claw_angle;
    assign move_time_ms = head.move_time_ms;
    assign phase        = head.phase;
    assign last         = head.last;

endmodule

`default_nettype wire

@@ hw/rtl/vsps_front.sv @@
// ============================================================================
// vsps_front
// Accepts camera reports, classifies them and holds them in a short queue.
// ============================================================================
`default_nettype none

module vsps_front
    import vsps_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic        found,
    input  wire logic [7:0]  blob_color,
    input  wire logic [8:0]  blob_x,
    input  wire logic [7:0]  blob_y,
    output vsps_item_t       item,
    output logic             item_valid,
    input  wire logic        item_take
);

    vsps_item_t         mem_reg [IQ_DEPTH];
    logic [IQ_AW-1:0]   wr_ptr_reg;
    logic [IQ_AW-1:0]   rd_ptr_reg;
    logic [IQ_AW:0]     count_reg;
    vsps_item_t         cls;
    logic               wr_en;
    logic               rd_en;

    // Classification of the incoming report
    always_comb
    begin
        cls.found    = found;
        cls.sortable = (blob_color >= COLOR_RED) && (blob_color <= COLOR_BLUE);
        cls.color    = blob_color;
        cls.err_x    = signed'({1'b0, blob_x}) - MID_X;
        cls.err_y    = signed'({1'b0, blob_y}) - MID_Y;
    end

    assign full       = (count_reg == (IQ_AW+1)'(IQ_DEPTH));
    assign item_valid = (count_reg != '0);
    assign item       = mem_reg[rd_ptr_reg];
    assign wr_en      = push && !full;
    assign rd_en      = item_take && item_valid;

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= cls;
        end
    end

    // Queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (wr_en && !rd_en)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (rd_en && !wr_en)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/vsps_outq.sv @@
// ============================================================================
// vsps_outq
// Result queue between the sequencer and the consumer.
// ============================================================================
`default_nettype none

module vsps_outq
    import vsps_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    res_push,
    input  wire vsps_result_t res_in,
    output vsps_oq_stat_t stat,
    output logic         empty,
    input  wire logic    pop,
    output vsps_result_t head
);

    vsps_result_t       mem_reg [OQ_DEPTH];
    logic [OQ_AW-1:0]   wr_ptr_reg;
    logic [OQ_AW-1:0]   rd_ptr_reg;
    logic [OQ_AW:0]     count_reg;
    logic               rd_en;

    assign empty      = (count_reg == '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign rd_en      = pop && !empty;
    assign stat.room2 = (count_reg <= (OQ_AW+1)'(OQ_DEPTH - 2));

    // Storage
    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            mem_reg[wr_ptr_reg] <= res_in;
        end
    end

    // Pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (res_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (res_push && !rd_en)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (rd_en && !res_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/vsps_core.sv @@
// ============================================================================
// vsps_core
// Sequencer back end: configuration registers, phase state and tracking math.
// ============================================================================
`default_nettype none

module vsps_core
    import vsps_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire vsps_item_t            item,
    input  wire logic                  item_valid,
    output logic                       item_take,
    input  wire vsps_oq_stat_t         oq_stat,
    output logic                       res_push,
    output vsps_result_t               res_out
);

    // Configuration
    logic signed [10:0] y_step_reg;
    logic signed [10:0] x_step_reg;
    logic [7:0]         deadband_reg;
    logic [7:0]         stable_reg;
    logic [7:0]         lost_max_reg;
    logic [12:0]        max_step_reg;

    // Control
    vsps_cstate_t       cstate_reg, cstate_next;
    vsps_phase_t        phase_reg, phase_next;
    logic               confirm_reg, confirm_next;
    logic [7:0]         color_reg, color_next;
    logic [7:0]         centred_reg, centred_next;
    logic [7:0]         missed_reg, missed_next;
    logic               moved_reg, moved_next;
    logic signed [15:0] aim_x_reg, aim_x_next;
    logic signed [15:0] aim_y_reg, aim_y_next;
    logic signed [15:0] pick_x_reg, pick_x_next;
    logic signed [15:0] pick_y_reg, pick_y_next;

    // Datapath
    vsps_item_t         item_reg;
    logic signed [20:0] prod_reg;
    logic [9:0]         err_abs_reg;
    logic signed [9:0]  err_sel;
    logic signed [10:0] gain_sel;
    logic signed [20:0] prod_next;
    logic [9:0]         err_abs_next;

    logic signed [20:0] lim;
    logic signed [20:0] corr;
    logic signed [17:0] base;
    logic signed [17:0] sum;
    logic signed [17:0] lo_lim;
    logic signed [17:0] hi_lim;
    logic signed [15:0] clamped;
    logic [7:0]         centred_inc;
    logic [7:0]         missed_inc;
    logic               is_y;
    logic               seen;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            y_step_reg   <= RST_Y_STEP;
            x_step_reg   <= RST_X_STEP;
            deadband_reg <= RST_DEADBAND;
            stable_reg   <= RST_STABLE;
            lost_max_reg <= RST_LOST_MAX;
            max_step_reg <= RST_MAX_STEP;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_Y_STEP:   y_step_reg   <= signed'(cfg_wdata[10:0]);
                REG_X_STEP:   x_step_reg   <= signed'(cfg_wdata[10:0]);
                REG_DEADBAND: deadband_reg <= cfg_wdata[7:0];
                REG_STABLE:   stable_reg   <= cfg_wdata[7:0];
                REG_LOST_MAX: lost_max_reg <= cfg_wdata[7:0];
                REG_MAX_STEP: max_step_reg <= cfg_wdata[12:0];
                default:      ;
            endcase
        end
    end

    // Multiply stage: pixel error times gain for the active axis
    assign is_y     = (phase_reg == PH_TRACK_Y);
    assign err_sel  = is_y ? item_reg.err_x : 10'(item_reg.err_y);
    assign gain_sel = is_y ? y_step_reg : x_step_reg;

    always_comb
    begin
        prod_next    = err_sel * gain_sel;
        err_abs_next = err_sel[9] ? 10'(-err_sel) : 10'(err_sel);
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            item_reg <= item;
        end
        if (cstate_reg == CS_MUL)
        begin
            prod_reg    <= prod_next;
            err_abs_reg <= err_abs_next;
        end
    end

    // Step clamp, add to aim, target clamp
    always_comb
    begin
        lim    = signed'({8'b0, max_step_reg});
        if (prod_reg > lim)
        begin
            corr = lim;
        end
        else if (prod_reg < -lim)
        begin
            corr = -lim;
        end
        else
        begin
            corr = prod_reg;
        end
        base   = is_y ? 18'(aim_y_reg) : 18'(aim_x_reg);
        lo_lim = is_y ? Y_MIN : X_MIN;
        hi_lim = is_y ? Y_MAX : X_MAX;
        sum    = base + corr[17:0];
        if (sum < lo_lim)
        begin
            clamped = lo_lim[15:0];
        end
        else if (sum > hi_lim)
        begin
            clamped = hi_lim[15:0];
        end
        else
        begin
            clamped = sum[15:0];
        end
    end

    assign centred_inc = (centred_reg == 8'hFF) ? centred_reg : centred_reg + 8'd1;
    assign missed_inc  = (missed_reg == 8'hFF) ? missed_reg : missed_reg + 8'd1;
    assign seen        = item_reg.found && (item_reg.color == color_reg);

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cstate_reg  <= CS_IDLE;
            phase_reg   <= PH_DETECT;
            confirm_reg <= 1'b0;
            color_reg   <= '0;
            centred_reg <= '0;
            missed_reg  <= '0;
            moved_reg   <= 1'b0;
            aim_x_reg   <= CAP_X;
            aim_y_reg   <= CAP_Y;
            pick_x_reg  <= CAP_X;
            pick_y_reg  <= CAP_Y;
        end
        else
        begin
            cstate_reg  <= cstate_next;
            phase_reg   <= phase_next;
            confirm_reg <= confirm_next;
            color_reg   <= color_next;
            centred_reg <= centred_next;
            missed_reg  <= missed_next;
            moved_reg   <= moved_next;
            aim_x_reg   <= aim_x_next;
            aim_y_reg   <= aim_y_next;
            pick_x_reg  <= pick_x_next;
            pick_y_reg  <= pick_y_next;
        end
    end

    // Sequencer: next state and results
    always_comb
    begin
        cstate_next  = cstate_reg;
        phase_next   = phase_reg;
        confirm_next = confirm_reg;
        color_next   = color_reg;
        centred_next = centred_reg;
        missed_next  = missed_reg;
        moved_next   = moved_reg;
        aim_x_next   = aim_x_reg;
        aim_y_next   = aim_y_reg;
        pick_x_next  = pick_x_reg;
        pick_y_next  = pick_y_reg;
        item_take    = 1'b0;
        res_push     = 1'b0;

        res_out.command      = CMD_NONE;
        res_out.pos_x        = '0;
        res_out.pos_y        = '0;
        res_out.pos_z        = '0;
        res_out.claw_angle   = CLAW_NONE;
        res_out.move_time_ms = T_NONE;
        res_out.phase        = phase_reg;
        res_out.last         = 1'b1;

        unique case (cstate_reg)
            CS_IDLE:
            begin
                if (item_valid && oq_stat.room2)
                begin
                    item_take   = 1'b1;
                    cstate_next = CS_MUL;
                end
            end

            CS_MUL:
            begin
                cstate_next = CS_EXEC;
            end

            CS_EXEC:
            begin
                res_push    = 1'b1;
                cstate_next = CS_IDLE;
                unique case (phase_reg)
                    PH_DETECT:
                    begin
                        if (item_reg.found && item_reg.sortable)
                        begin
                            if (confirm_reg)
                            begin
                                confirm_next = 1'b0;
                                color_next   = item_reg.color;
                                aim_x_next   = CAP_X;
                                aim_y_next   = CAP_Y;
                                centred_next = '0;
                                missed_next  = '0;
                                moved_next   = 1'b0;
                                phase_next   = PH_TRACK_Y;
                            end
                            else
                            begin
                                confirm_next = 1'b1;
                            end
                        end
                        else
                        begin
                            confirm_next = 1'b0;
                        end
                    end

                    PH_TRACK_Y, PH_TRACK_X:
                    begin
                        if (!seen)
                        begin
                            // Target lost
                            centred_next = '0;
                            if (moved_reg)
                            begin
                                pick_x_next = aim_x_reg;
                                pick_y_next = aim_y_reg;
                                phase_next  = PH_APPROACH;
                            end
                            else
                            begin
                                missed_next = missed_inc;
                                if (missed_inc >= lost_max_reg)
                                begin
                                    confirm_next = 1'b0;
                                    color_next   = '0;
                                    missed_next  = '0;
                                    moved_next   = 1'b0;
                                    aim_x_next   = CAP_X;
                                    aim_y_next   = CAP_Y;
                                    pick_x_next  = CAP_X;
                                    pick_y_next  = CAP_Y;
                                    phase_next   = PH_DETECT;
                                    res_out.command      = CMD_ARM;
                                    res_out.pos_x        = CAP_X;
                                    res_out.pos_y        = CAP_Y;
                                    res_out.pos_z        = CAP_Z;
                                    res_out.move_time_ms = T_HOME;
                                end
                            end
                        end
                        else if (err_abs_reg <= {2'b0, deadband_reg})
                        begin
                            // Centred on this axis
                            missed_next  = '0;
                            centred_next = centred_inc;
                            if (centred_inc >= stable_reg)
                            begin
                                if (is_y)
                                begin
                                    centred_next = '0;
                                    phase_next   = PH_TRACK_X;
                                end
                                else
                                begin
                                    pick_x_next = aim_x_reg;
                                    pick_y_next = aim_y_reg;
                                    phase_next  = PH_APPROACH;
                                end
                            end
                        end
                        else
                        begin
                            // Corrective move
                            missed_next  = '0;
                            centred_next = '0;
                            moved_next   = 1'b1;
                            if (is_y)
                            begin
                                aim_y_next = clamped;
                            end
                            else
                            begin
                                aim_x_next = clamped;
                            end
                            res_out.command      = CMD_ARM;
                            res_out.pos_x        = is_y ? aim_x_reg : clamped;
                            res_out.pos_y        = is_y ? clamped : aim_y_reg;
                            res_out.pos_z        = CAP_Z;
                            res_out.move_time_ms = T_TRACK;
                        end
                    end

                    PH_APPROACH:
                    begin
                        res_out.command      = CMD_ARM;
                        res_out.pos_x        = pick_x_reg;
                        res_out.pos_y        = pick_y_reg;
                        res_out.pos_z        = APPR_Z;
                        res_out.move_time_ms = T_MOVE;
                        phase_next           = PH_GRAB;
                    end

                    PH_GRAB:
                    begin
                        res_out.command      = CMD_ARM;
                        res_out.pos_x        = pick_x_reg;
                        res_out.pos_y        = pick_y_reg;
                        res_out.pos_z        = GRAB_Z;
                        res_out.move_time_ms = T_MOVE;
                        phase_next           = PH_CLOSE;
                    end

                    PH_CLOSE:
                    begin
                        res_out.command      = CMD_CLAW;
                        res_out.move_time_ms = T_CLAW;
                        phase_next           = PH_LIFT;
                    end

                    PH_LIFT:
                    begin
                        res_out.command      = CMD_ARM;
                        res_out.pos_x        = pick_x_reg;
                        res_out.pos_y        = pick_y_reg;
                        res_out.pos_z        = CAP_Z;
                        res_out.move_time_ms = T_MOVE;
                        phase_next           = PH_PLACE;
                    end

                    PH_PLACE:
                    begin
                        // Move to the bin, claw opens in the next cycle
                        res_out.command      = CMD_ARM;
                        res_out.pos_z        = PLACE_Z;
                        res_out.move_time_ms = T_MOVE;
                        res_out.last         = 1'b0;
                        priority if (color_reg == COLOR_RED)
                        begin
                            res_out.pos_x = RED_X;
                            res_out.pos_y = RED_Y;
                        end
                        else if (color_reg == COLOR_GREEN)
                        begin
                            res_out.pos_x = GRN_X;
                            res_out.pos_y = GRN_Y;
                        end
                        else if (color_reg == COLOR_BLUE)
                        begin
                            res_out.pos_x = BLU_X;
                            res_out.pos_y = BLU_Y;
                        end
                        else
                        begin
                            res_out.pos_x = CAP_X;
                            res_out.pos_y = CAP_Y;
                            res_out.pos_z = APPR_Z;
                        end
                        phase_next  = PH_RETURN;
                        cstate_next = CS_OPEN;
                    end

                    default:
                    begin
                        // Return to capture pose and restart
                        res_out.command      = CMD_ARM;
                        res_out.pos_x        = CAP_X;
                        res_out.pos_y        = CAP_Y;
                        res_out.pos_z        = CAP_Z;
                        res_out.move_time_ms = T_HOME;
                        confirm_next = 1'b0;
                        color_next   = '0;
                        centred_next = '0;
                        missed_next  = '0;
                        moved_next   = 1'b0;
                        aim_x_next   = CAP_X;
                        aim_y_next   = CAP_Y;
                        pick_x_next  = CAP_X;
                        pick_y_next  = CAP_Y;
                        phase_next   = PH_DETECT;
                    end
                endcase
                res_out.phase = phase_next;
            end

            CS_OPEN:
            begin
                // Second result of the place step
                res_push             = 1'b1;
                res_out.command      = CMD_CLAW;
                res_out.claw_angle   = CLAW_OPEN;
                res_out.move_time_ms = T_NONE;
                res_out.phase        = phase_reg;
                res_out.last         = 1'b1;
                cstate_next          = CS_IDLE;
            end

            default:
            begin
                cstate_next = CS_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ dv/vsps_tb_pkg.sv @@
// ============================================================================
// vsps_tb_pkg
// Sequence predictor and result scoreboard for the pick-and-place sequencer.
// Every accepted report is run through a local copy of the sequencer state to
// produce the results it should cause. Those results wait in order until the
// block delivers them, and each delivered result is compared field by field.
// ============================================================================
`default_nettype none

package vsps_tb_pkg;

    import vsps_pkg::*;

    // Arm poses and limits, 0.001 cm
    localparam int HOME_X   = 15000;
    localparam int HOME_Y   = 0;
    localparam int HOME_Z   = -3000;
    localparam int HOVER_Z  = 4000;
    localparam int GRIP_Z   = -7000;
    localparam int DROP_Z   = -5000;
    localparam int AIM_X_LO = 10000;
    localparam int AIM_X_HI = 20000;
    localparam int AIM_Y_LO = -10000;
    localparam int AIM_Y_HI = 10000;

    // Image centre, pixels
    localparam int CENTRE_X = 160;
    localparam int CENTRE_Y = 120;

    class vsps_sequence_scoreboard;

        // Register copy
        int y_gain;
        int x_gain;
        int deadband;
        int stable_need;
        int lost_limit;
        int step_lim;

        // Sequencer state copy
        vsps_phase_t ph;
        bit          pending_confirm;
        logic [7:0]  color_lock;
        int          n_centred;
        int          n_missed;
        int          n_moves;
        int          aim_x;
        int          aim_y;
        int          pick_x;
        int          pick_y;

        vsps_result_t expected_q[$];
        int           n_errors;

        function new();
            y_gain      = -15;
            x_gain      = 30;
            deadband    = 8;
            stable_need = 3;
            lost_limit  = 10;
            step_lim    = 500;
            ph          = PH_DETECT;
            n_errors    = 0;
            reset_track();
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function int clip(int v, int lo, int hi);
            if (v < lo)
                return lo;
            if (v > hi)
                return hi;
            return v;
        endfunction

        function vsps_result_t mk(vsps_cmd_t cmd, int x, int y, int z, int claw, int ms);
            vsps_result_t r;
            r.command      = cmd;
            r.pos_x        = x[15:0];
            r.pos_y        = y[15:0];
            r.pos_z        = z[15:0];
            r.claw_angle   = claw[7:0];
            r.move_time_ms = ms[9:0];
            r.phase        = '0;
            r.last         = 1'b0;
            return r;
        endfunction

        function void reset_track();
            pending_confirm = 1'b0;
            color_lock      = 8'd0;
            n_centred       = 0;
            n_missed        = 0;
            n_moves         = 0;
            aim_x           = HOME_X;
            aim_y           = HOME_Y;
            pick_x          = HOME_X;
            pick_y          = HOME_Y;
        endfunction

        function void set_pick();
            pick_x = clip(aim_x, AIM_X_LO, AIM_X_HI);
            pick_y = clip(aim_y, AIM_Y_LO, AIM_Y_HI);
        endfunction

        // Register write; narrow registers keep their low bits only
        function void apply_write(logic [2:0] idx, logic [12:0] v);
            case (idx)
                REG_Y_STEP:   y_gain      = int'($signed(v[10:0]));
                REG_X_STEP:   x_gain      = int'($signed(v[10:0]));
                REG_DEADBAND: deadband    = int'(v[7:0]);
                REG_STABLE:   stable_need = int'(v[7:0]);
                REG_LOST_MAX: lost_limit  = int'(v[7:0]);
                REG_MAX_STEP: step_lim    = int'(v);
                default: ;
            endcase
        endfunction

        // One accepted report: advance the sequence, queue what it causes
        function void note_report(logic f, logic [7:0] c, logic [8:0] bx, logic [7:0] by);
            vsps_result_t r [2];
            int  n;
            int  err;
            int  mag;
            int  step;
            bit  sortable;
            bit  on_target;
            n         = 1;
            sortable  = (c >= COLOR_RED) && (c <= COLOR_BLUE);
            on_target = f && (c == color_lock);
            r[0]      = mk(CMD_NONE, 0, 0, 0, 0, 0);
            r[1]      = r[0];

            case (ph)
                PH_DETECT:
                begin
                    if (f && sortable)
                    begin
                        if (pending_confirm)
                        begin
                            // second sighting in a row locks this color
                            pending_confirm = 1'b0;
                            color_lock      = c;
                            aim_x           = HOME_X;
                            aim_y           = HOME_Y;
                            n_centred       = 0;
                            n_missed        = 0;
                            n_moves         = 0;
                            ph              = PH_TRACK_Y;
                        end
                        else
                            pending_confirm = 1'b1;
                    end
                    else
                        pending_confirm = 1'b0;
                end
                PH_TRACK_Y, PH_TRACK_X:
                begin
                    if (!on_target)
                    begin
                        // target lost: go for the last aim if we ever moved
                        n_centred = 0;
                        if (n_moves > 0)
                        begin
                            set_pick();
                            ph = PH_APPROACH;
                        end
                        else
                        begin
                            if (n_missed < 255)
                                n_missed++;
                            if (n_missed >= lost_limit)
                            begin
                                reset_track();
                                r[0] = mk(CMD_ARM, HOME_X, HOME_Y, HOME_Z, 0, 500);
                                ph   = PH_DETECT;
                            end
                        end
                    end
                    else
                    begin
                        n_missed = 0;
                        err = (ph == PH_TRACK_Y) ? int'(bx) - CENTRE_X : int'(by) - CENTRE_Y;
                        mag = (err < 0) ? -err : err;
                        if (mag <= deadband)
                        begin
                            if (n_centred < 255)
                                n_centred++;
                            if (n_centred >= stable_need)
                            begin
                                if (ph == PH_TRACK_Y)
                                begin
                                    n_centred = 0;
                                    ph        = PH_TRACK_X;
                                end
                                else
                                begin
                                    set_pick();
                                    ph = PH_APPROACH;
                                end
                            end
                        end
                        else
                        begin
                            // proportional move, step and target clamped
                            n_centred = 0;
                            if (ph == PH_TRACK_Y)
                            begin
                                step  = clip(err * y_gain, -step_lim, step_lim);
                                aim_y = clip(aim_y + step, AIM_Y_LO, AIM_Y_HI);
                            end
                            else
                            begin
                                step  = clip(err * x_gain, -step_lim, step_lim);
                                aim_x = clip(aim_x + step, AIM_X_LO, AIM_X_HI);
                            end
                            r[0] = mk(CMD_ARM, aim_x, aim_y, HOME_Z, 0, 80);
                            if (n_moves < 65535)
                                n_moves++;
                        end
                    end
                end
                PH_APPROACH:
                begin
                    r[0] = mk(CMD_ARM, pick_x, pick_y, HOVER_Z, 0, 1000);
                    ph   = PH_GRAB;
                end
                PH_GRAB:
                begin
                    r[0] = mk(CMD_ARM, pick_x, pick_y, GRIP_Z, 0, 1000);
                    ph   = PH_CLOSE;
                end
                PH_CLOSE:
                begin
                    r[0] = mk(CMD_CLAW, 0, 0, 0, 0, 200);
                    ph   = PH_LIFT;
                end
                PH_LIFT:
                begin
                    r[0] = mk(CMD_ARM, pick_x, pick_y, HOME_Z, 0, 1000);
                    ph   = PH_PLACE;
                end
                PH_PLACE:
                begin
                    // drop spot by color, then open the claw
                    case (color_lock)
                        COLOR_RED:   r[0] = mk(CMD_ARM, 5000, 12000, DROP_Z, 0, 1000);
                        COLOR_GREEN: r[0] = mk(CMD_ARM, 5000, -12000, DROP_Z, 0, 1000);
                        COLOR_BLUE:  r[0] = mk(CMD_ARM, 20000, 0, DROP_Z, 0, 1000);
                        default:     r[0] = mk(CMD_ARM, HOME_X, HOME_Y, HOVER_Z, 0, 1000);
                    endcase
                    r[1] = mk(CMD_CLAW, 0, 0, 0, 90, 0);
                    n    = 2;
                    ph   = PH_RETURN;
                end
                PH_RETURN:
                begin
                    r[0] = mk(CMD_ARM, HOME_X, HOME_Y, HOME_Z, 0, 500);
                    reset_track();
                    ph   = PH_DETECT;
                end
                default:
                begin
                    reset_track();
                    r[0] = mk(CMD_ARM, HOME_X, HOME_Y, HOME_Z, 0, 500);
                    ph   = PH_DETECT;
                end
            endcase

            for (int k = 0; k < n; k++)
            begin
                r[k].phase = ph;
                r[k].last  = (k == n - 1);
                expected_q.push_back(r[k]);
            end
        endfunction

        function void check_field(string field, logic signed [31:0] want,
                                  logic signed [31:0] got);
            if (got !== want)
            begin
                n_errors++;
                $error("%s mismatch: expected %0d, actual %0d", field, want, got);
            end
        endfunction

        // One delivered result against the oldest one queued
        function void check_result(vsps_result_t got);
            vsps_result_t want;
            if (expected_q.size() == 0)
            begin
                n_errors++;
                $error("result transfer with nothing expected: command %0d phase %0d",
                       got.command, got.phase);
                return;
            end
            want = expected_q.pop_front();
            check_field("command", want.command, got.command);
            check_field("pos_x", want.pos_x, got.pos_x);
            check_field("pos_y", want.pos_y, got.pos_y);
            check_field("pos_z", want.pos_z, got.pos_z);
            check_field("claw_angle", want.claw_angle, got.claw_angle);
            check_field("move_time_ms", want.move_time_ms, got.move_time_ms);
            check_field("phase", want.phase, got.phase);
            check_field("last", want.last, got.last);
        endfunction

    endclass

endpackage

`default_nettype wire

@@ dv/tb_top.sv @@
// ============================================================================
// tb_top
// Testbench for visual_servo_pick_place_sequencer_unit.
// A short directed run walks one full pick and place, then randomized reports
// (mostly plausible tracking streams, some noise) run under several register
// settings and traffic patterns: free flow, sparse sender, stalling receiver,
// light idling on both sides, and one long receiver hold-off. Results are
// checked in order against the sequence predictor in vsps_tb_pkg.
// ============================================================================
`default_nettype none

module tb_top;

    import vsps_pkg::*;
    import vsps_tb_pkg::*;

    localparam int QUIET_LIMIT = 3000;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS = 146;
    localparam int NUM_PHASES  = 7;

    // Indexes past the last register, written to see them ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  push       = 1'b0;
    logic                  full;
    logic                  found      = 1'b0;
    logic [7:0]            blob_color = 8'd0;
    logic [8:0]            blob_x     = 9'd0;
    logic [7:0]            blob_y     = 8'd0;
    logic                  empty;
    logic                  pop        = 1'b0;
    logic [1:0]            command;
    logic signed [15:0]    pos_x;
    logic signed [15:0]    pos_y;
    logic signed [15:0]    pos_z;
    logic [7:0]            claw_angle;
    logic [9:0]            move_time_ms;
    logic [3:0]            phase;
    logic                  last;
    logic                  cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

    vsps_sequence_scoreboard sb;

    // Traffic control shared by the sender and receiver processes
    int         send_idle_pct = 0;
    int         stall_pct     = 0;
    bit         hold_request  = 1'b0;
    int         hold_left     = 0;
    int         quiet_cycles  = 0;
    bit         moved;
    int         cur_deadband  = 8;
    logic [7:0] track_color   = COLOR_RED;
    vsps_result_t seen_res;

    // Clock
    always
    begin
        #6;
        clk = 1'b1;
        #6;
        clk = 1'b0;
    end

    visual_servo_pick_place_sequencer_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .found        (found),
        .blob_color   (blob_color),
        .blob_x       (blob_x),
        .blob_y       (blob_y),
        .empty        (empty),
        .pop          (pop),
        .command      (command),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .claw_angle   (claw_angle),
        .move_time_ms (move_time_ms),
        .phase        (phase),
        .last         (last),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    // Transfer monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            moved = 1'b0;
            if (push && !full)
            begin
                sb.note_report(found, blob_color, blob_x, blob_y);
                moved = 1'b1;
            end
            if (pop && !empty)
            begin
                seen_res.command      = vsps_cmd_t'(command);
                seen_res.pos_x        = pos_x;
                seen_res.pos_y        = pos_y;
                seen_res.pos_z        = pos_z;
                seen_res.claw_angle   = claw_angle;
                seen_res.move_time_ms = move_time_ms;
                seen_res.phase        = phase;
                seen_res.last         = last;
                sb.check_result(seen_res);
                moved = 1'b1;
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("visual_servo_pick_place_sequencer_unit verification failed");
                $finish;
            end
        end
    end

    // Result side: random stalls, plus a counted hold-off on request
    initial
    begin
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Offer one report and hold it until the transfer
    task automatic send_report(input logic f, input logic [7:0] c,
                               input logic [8:0] x, input logic [7:0] y);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push       <= 1'b1;
        found      <= f;
        blob_color <= c;
        blob_x     <= x;
        blob_y     <= y;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    // Stop offering and wait for every queued result
    task automatic settle();
        push <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge clk);
        sb.apply_write(idx, v);
    endtask

    // Write all registers; unused upper data bits carry junk
    task automatic set_regs(input int ys, input int xs, input int db,
                            input int st, input int lm, input int ms);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom);
        cfg_write(REG_Y_STEP, {junk[12:11], ys[10:0]});
        junk = CFG_DATA_W'($urandom);
        cfg_write(REG_X_STEP, {junk[12:11], xs[10:0]});
        junk = CFG_DATA_W'($urandom);
        cfg_write(REG_DEADBAND, {junk[12:8], db[7:0]});
        junk = CFG_DATA_W'($urandom);
        cfg_write(REG_STABLE, {junk[12:8], st[7:0]});
        junk = CFG_DATA_W'($urandom);
        cfg_write(REG_LOST_MAX, {junk[12:8], lm[7:0]});
        cfg_write(REG_MAX_STEP, ms[12:0]);
        junk = CFG_DATA_W'($urandom);
        cfg_write(REG_SPARE_6, junk);
        junk = CFG_DATA_W'($urandom);
        cfg_write(REG_SPARE_7, junk);
        cfg_we       <= 1'b0;
        cur_deadband  = db & 8'hFF;
        @(posedge clk);
    endtask

    // Mostly plausible tracking reports around the centre, some pure noise
    task automatic gen_report(output logic f, output logic [7:0] c,
                              output logic [8:0] x, output logic [7:0] y);
        int w;
        int v;
        if ($urandom_range(99) < 20)
        begin
            f = 1'($urandom);
            c = 8'($urandom);
            x = 9'($urandom);
            y = 8'($urandom);
        end
        else
        begin
            if ($urandom_range(99) < 4)
                track_color = 8'($urandom_range(3, 1));
            f = ($urandom_range(99) < 93);
            c = track_color;
            if ($urandom_range(99) < 6)
                c = 8'($urandom_range(7));
            w = cur_deadband + 3;
            if ($urandom_range(99) < 65)
            begin
                v = CENTRE_X + int'($urandom_range(2 * w)) - w;
                x = (v < 0) ? 9'd0 : (v > 511) ? 9'd511 : v[8:0];
            end
            else
                x = 9'($urandom_range(511));
            if ($urandom_range(99) < 65)
            begin
                v = CENTRE_Y + int'($urandom_range(2 * w)) - w;
                y = (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : v[7:0];
            end
            else
                y = 8'($urandom_range(255));
        end
    endtask

    // Main stimulus
    initial
    begin : stimulus
        logic       f;
        logic [7:0] c;
        logic [8:0] x;
        logic [7:0] y;

        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed walk at reset register values
        send_report(1'b0, 8'd0, 9'd0, 8'd0);            // nothing seen
        send_report(1'b1, 8'd0, 9'd160, 8'd120);        // unsortable colors
        send_report(1'b1, 8'd4, 9'd160, 8'd120);
        send_report(1'b1, 8'd255, 9'd511, 8'd255);
        send_report(1'b1, COLOR_RED, 9'd160, 8'd120);   // first sighting
        send_report(1'b1, COLOR_GREEN, 9'd160, 8'd120); // second one locks green
        send_report(1'b1, COLOR_GREEN, 9'd0, 8'd120);   // far left, step clamps
        send_report(1'b1, COLOR_GREEN, 9'd511, 8'd0);   // far right
        send_report(1'b1, COLOR_GREEN, 9'd168, 8'd7);   // centred on deadband edge
        send_report(1'b1, COLOR_GREEN, 9'd152, 8'd200);
        send_report(1'b1, COLOR_GREEN, 9'd160, 8'd120);
        send_report(1'b1, COLOR_GREEN, 9'd160, 8'd0);   // y axis extremes
        send_report(1'b1, COLOR_GREEN, 9'd160, 8'd255);
        send_report(1'b1, COLOR_GREEN, 9'd0, 8'd128);
        send_report(1'b1, COLOR_GREEN, 9'd511, 8'd112);
        send_report(1'b1, COLOR_GREEN, 9'd160, 8'd120);
        send_report(1'b0, 8'd0, 9'd0, 8'd0);            // approach .. return ignore reports
        send_report(1'b1, 8'd255, 9'd511, 8'd255);
        send_report(1'b1, COLOR_RED, 9'd160, 8'd120);
        send_report(1'b0, COLOR_BLUE, 9'd100, 8'd50);
        send_report(1'b1, 8'd170, 9'd341, 8'd85);
        send_report(1'b1, COLOR_GREEN, 9'd0, 8'd240);
        send_report(1'b1, COLOR_BLUE, 9'd320, 8'd240);  // first blue sighting, next one locks
        send_report(1'b1, COLOR_BLUE, 9'd160, 8'd120);
        send_report(1'b1, COLOR_RED, 9'd160, 8'd120);   // wrong color before any move

        // Randomized phases
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            settle();
            case (p)
                0: set_regs(-15, 30, 8, 3, 10, 500);
                1: set_regs(-1024, 1023, 0, 1, 1, 8191);
                2: set_regs(1000, -1000, 255, 255, 255, 0);
                3: set_regs(int'($urandom_range(2000)) - 1000, int'($urandom_range(2000)) - 1000,
                            8, 0, 0, $urandom_range(5000));
                5: set_regs(-15, 30, 20, 2, 4, 5000);
                default: set_regs(int'($urandom_range(2000)) - 1000,
                                  int'($urandom_range(2000)) - 1000,
                                  $urandom_range(40), $urandom_range(6, 1),
                                  $urandom_range(12, 1), $urandom_range(5000));
            endcase
            case (p % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 80;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 80;
                end
                default:
                begin
                    send_idle_pct = 18;
                    stall_pct     = 18;
                end
            endcase
            // long receiver hold-off while reports keep coming
            if (p == 4)
                hold_request = 1'b1;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (p == 0 && i == PHASE_ITEMS / 2)
                    settle();
                gen_report(f, c, x, y);
                send_report(f, c, x, y);
            end
        end

        settle();
        repeat (40) @(posedge clk);
        if (sb.n_errors == 0 && sb.pending() == 0)
            $display("visual_servo_pick_place_sequencer_unit verification clean");
        else
            $display("visual_servo_pick_place_sequencer_unit verification failed");
        $finish;
    end

endmodule

`default_nettype wire

@@ visual_servo_pick_place_sequencer_unit.f @@
hw/rtl/vsps_pkg.sv
hw/rtl/vsps_front.sv
hw/rtl/vsps_outq.sv
hw/rtl/vsps_core.sv
hw/rtl/visual_servo_pick_place_sequencer_unit.sv
dv/vsps_tb_pkg.sv
dv/tb_top.sv
